FILE: hdl/pointer_gesture_recognizer_core_defines.svh
// Assertion macros used by the gesture recognizer top level.
`ifndef POINTER_GESTURE_RECOGNIZER_CORE_DEFINES_SVH
`define POINTER_GESTURE_RECOGNIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PGR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgr assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgr assertion failed");

`endif

FILE: hdl/pgr_pkg.sv
// Package with types, codes and helpers of the pointer gesture recognizer.
`timescale 1ns / 1ps

package pgr_pkg;

    // input request modes
    typedef enum logic [2:0] {
        MODE_LPRESS   = 3'd0,
        MODE_LRELEASE = 3'd1,
        MODE_RPRESS   = 3'd2,
        MODE_MOTION   = 3'd3,
        MODE_TICK     = 3'd4
    } t_mode;

    // result kinds
    typedef enum logic [2:0] {
        KIND_DOWN   = 3'd0,
        KIND_UP     = 3'd1,
        KIND_CLICK  = 3'd2,
        KIND_DOUBLE = 3'd3,
        KIND_RIGHT  = 3'd4,
        KIND_MOVE   = 3'd5
    } t_kind;

    // configuration register indexes
    localparam logic [1:0] CFG_DC_WINDOW = 2'd0;
    localparam logic [1:0] CFG_SLOP      = 2'd1;
    localparam logic [1:0] CFG_CANCEL    = 2'd2;
    localparam logic [1:0] CFG_LONG      = 2'd3;

    // configuration reset values
    localparam logic [15:0] RST_DC_WINDOW = 16'd500;
    localparam logic [7:0]  RST_SLOP      = 8'd5;
    localparam logic [7:0]  RST_CANCEL    = 8'd10;
    localparam logic [15:0] RST_LONG      = 16'd800;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // one result without its stamp
    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_result;

    // all results of one request
    typedef struct packed {
        t_result     first;
        t_result     second;
        logic        two;
        logic [31:0] stamp;
    } t_pair;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // per-axis distance of two signed coordinates
    function automatic logic [16:0] f_absdiff(logic signed [15:0] a, logic signed [15:0] b);
        logic [16:0] d;
        d = {a[15], a} - {b[15], b};
        return d[16] ? (~d + 17'd1) : d;
    endfunction

endpackage

FILE: hdl/pgr_front.sv
// Front part: accepts requests, keeps gesture state and builds the result pair.
`timescale 1ns / 1ps

module pgr_front import pgr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [31:0]        i_time_ms,
    input  t_q_stat            i_q_stat,
    output logic               o_push,
    output t_pair              o_pair
);

    // configuration
    logic [15:0] r_dc_win;
    logic [7:0]  r_slop;
    logic [7:0]  r_cancel;
    logic [15:0] r_long;

    // gesture state
    logic               r_held,       n_held;
    logic               r_fired,      n_fired;
    logic signed [15:0] r_press_x,    n_press_x;
    logic signed [15:0] r_press_y,    n_press_y;
    logic [31:0]        r_press_time, n_press_time;
    logic [31:0]        r_click_time, n_click_time;
    logic signed [15:0] r_click_x,    n_click_x;
    logic signed [15:0] r_click_y,    n_click_y;

    logic       accept;
    logic [1:0] m_cnt;
    t_kind      m_kind0;
    t_kind      m_kind1;
    logic       lp;
    logic       dbl;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_win <= RST_DC_WINDOW;
            r_slop   <= RST_SLOP;
            r_cancel <= RST_CANCEL;
            r_long   <= RST_LONG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DC_WINDOW: r_dc_win <= i_cfg_data;
                CFG_SLOP:      r_slop   <= i_cfg_data[7:0];
                CFG_CANCEL:    r_cancel <= i_cfg_data[7:0];
                CFG_LONG:      r_long   <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // double-click test against the last click
    assign dbl = ((i_time_ms - r_click_time) < {16'd0, r_dc_win}) &&
                 (f_absdiff(i_pos_x, r_click_x) < {9'd0, r_slop}) &&
                 (f_absdiff(i_pos_y, r_click_y) < {9'd0, r_slop});

    // mode handling, then the long-press check
    always_comb begin
        n_held       = r_held;
        n_fired      = r_fired;
        n_press_x    = r_press_x;
        n_press_y    = r_press_y;
        n_press_time = r_press_time;
        n_click_time = r_click_time;
        n_click_x    = r_click_x;
        n_click_y    = r_click_y;
        m_cnt        = 2'd0;
        m_kind0      = KIND_DOWN;
        m_kind1      = KIND_CLICK;
        lp           = 1'b0;
        unique case (t_mode'(i_mode))
            MODE_LPRESS: begin
                m_cnt        = 2'd1;
                m_kind0      = KIND_DOWN;
                n_held       = 1'b1;
                n_press_x    = i_pos_x;
                n_press_y    = i_pos_y;
                n_press_time = i_time_ms;
                n_fired      = 1'b0;
            end
            MODE_LRELEASE: begin
                if (r_fired) begin
                    // release after a fired long press is swallowed
                    n_held  = 1'b0;
                    n_fired = 1'b0;
                end else begin
                    m_cnt   = 2'd2;
                    m_kind0 = KIND_UP;
                    n_held  = 1'b0;
                    if (dbl) begin
                        m_kind1      = KIND_DOUBLE;
                        n_click_time = 32'd0;
                    end else begin
                        m_kind1      = KIND_CLICK;
                        n_click_time = i_time_ms;
                        n_click_x    = i_pos_x;
                        n_click_y    = i_pos_y;
                    end
                end
            end
            MODE_RPRESS: begin
                m_cnt   = 2'd1;
                m_kind0 = KIND_RIGHT;
            end
            MODE_MOTION: begin
                m_cnt   = 2'd1;
                m_kind0 = KIND_MOVE;
                if (r_held &&
                    ((f_absdiff(i_pos_x, r_press_x) > {9'd0, r_cancel}) ||
                     (f_absdiff(i_pos_y, r_press_y) > {9'd0, r_cancel}))) begin
                    n_held = 1'b0;
                end
            end
            default: ;
        endcase
        // long press fires at the press position
        if (n_held && !n_fired && ((i_time_ms - n_press_time) >= {16'd0, r_long})) begin
            lp      = 1'b1;
            n_fired = 1'b1;
            n_held  = 1'b0;
        end
    end

    // result pair toward the queue
    always_comb begin
        o_pair.stamp = i_time_ms;
        o_pair.first = '{kind: m_kind0, x: i_pos_x, y: i_pos_y};
        o_pair.second = '{kind: m_kind1, x: i_pos_x, y: i_pos_y};
        o_pair.two = 1'b0;
        priority case (m_cnt)
            2'd0: begin
                o_pair.first = '{kind: KIND_RIGHT, x: n_press_x, y: n_press_y};
            end
            2'd1: begin
                o_pair.second = '{kind: KIND_RIGHT, x: n_press_x, y: n_press_y};
                o_pair.two    = lp;
            end
            default: begin
                o_pair.two = 1'b1;
            end
        endcase
    end

    assign o_push = accept && ((m_cnt != 2'd0) || lp);

    // state update on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= 1'b0;
            r_fired      <= 1'b0;
            r_press_x    <= '0;
            r_press_y    <= '0;
            r_press_time <= '0;
            r_click_time <= '0;
            r_click_x    <= '0;
            r_click_y    <= '0;
        end else if (accept) begin
            r_held       <= n_held;
            r_fired      <= n_fired;
            r_press_x    <= n_press_x;
            r_press_y    <= n_press_y;
            r_press_time <= n_press_time;
            r_click_time <= n_click_time;
            r_click_x    <= n_click_x;
            r_click_y    <= n_click_y;
        end
    end

endmodule

FILE: hdl/pgr_queue.sv
// Short queue of result pairs between the front and the back.
`timescale 1ns / 1ps

module pgr_queue import pgr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_pair   i_data,
    input  logic    i_pop,
    output t_pair   o_data,
    output t_q_stat o_stat
);

    t_pair            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, n_wr;
    logic [QAW-1:0]   r_rd, n_rd;
    logic [QCW-1:0]   r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == QCW'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rd];

    // pointer and fill count
    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + QCW'(i_push) - QCW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: hdl/pgr_back.sv
// Back part: drains result pairs and drives one result per cycle while i_ready is high.
`timescale 1ns / 1ps

module pgr_back import pgr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_pair              i_data,
    input  t_q_stat            i_q_stat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_kind,
    output logic signed [15:0] o_at_x,
    output logic signed [15:0] o_at_y,
    output logic [31:0]        o_stamp_ms,
    output logic               o_last
);

    // output register
    logic               r_valid, n_valid;
    t_kind              r_kind,  n_kind;
    logic signed [15:0] r_x,     n_x;
    logic signed [15:0] r_y,     n_y;
    logic [31:0]        r_stamp, n_stamp;
    logic               r_last,  n_last;

    // pending second result of the current pair
    logic    r_pend_valid, n_pend_valid;
    t_result r_pend,       n_pend;

    logic out_free;

    assign out_free = !r_valid || i_ready;
    assign o_pop    = out_free && !r_pend_valid && !i_q_stat.empty;

    // load the next result when the output register frees up
    always_comb begin
        n_valid      = r_valid;
        n_kind       = r_kind;
        n_x          = r_x;
        n_y          = r_y;
        n_stamp      = r_stamp;
        n_last       = r_last;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        if (out_free) begin
            priority if (r_pend_valid) begin
                n_valid      = 1'b1;
                n_kind       = r_pend.kind;
                n_x          = r_pend.x;
                n_y          = r_pend.y;
                n_last       = 1'b1;
                n_pend_valid = 1'b0;
            end else if (!i_q_stat.empty) begin
                n_valid      = 1'b1;
                n_kind       = i_data.first.kind;
                n_x          = i_data.first.x;
                n_y          = i_data.first.y;
                n_stamp      = i_data.stamp;
                n_last       = !i_data.two;
                n_pend_valid = i_data.two;
                n_pend       = i_data.second;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_x     <= n_x;
        r_y     <= n_y;
        r_stamp <= n_stamp;
        r_last  <= n_last;
        r_pend  <= n_pend;
    end

    assign o_valid    = r_valid;
    assign o_kind     = r_kind;
    assign o_at_x     = r_x;
    assign o_at_y     = r_y;
    assign o_stamp_ms = r_stamp;
    assign o_last     = r_last;

endmodule

FILE: hdl/pointer_gesture_recognizer_core.sv
// Path: a request's first result is written into the queue, then into the back's output register.
// Throughput: one request per cycle into the front while the queue is not full; the back drives
// one result per cycle while i_ready is high, so two-result requests drain slower (four-deep queue).
// Reset: i_rst_n is synchronous, active low; it empties the queue and output stage,
// clears the gesture state and loads the default configuration.
`timescale 1ns / 1ps
`include "pointer_gesture_recognizer_core_defines.svh"

module pointer_gesture_recognizer_core import pgr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [31:0]        i_time_ms,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_kind,
    output logic signed [15:0] o_at_x,
    output logic signed [15:0] o_at_y,
    output logic [31:0]        o_stamp_ms,
    output logic               o_last
);

    logic    push;
    logic    pop;
    t_pair   push_pair;
    t_pair   pop_pair;
    t_q_stat q_stat;

    // request intake and classification
    pgr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_time_ms  (i_time_ms),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_pair     (push_pair)
    );

    // decoupling queue
    pgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_pair),
        .i_pop   (pop),
        .o_data  (pop_pair),
        .o_stat  (q_stat)
    );

    // result serializer
    pgr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (pop_pair),
        .i_q_stat   (q_stat),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_at_x     (o_at_x),
        .o_at_y     (o_at_y),
        .o_stamp_ms (o_stamp_ms),
        .o_last     (o_last)
    );

    // a non-final result is always followed at once by the final one of the same request
    `PGR_ASSERT_NEXT(a_second_ready, i_clk, i_rst_n, o_valid && !o_last && i_ready, o_valid)
    `PGR_ASSERT_NEXT(a_second_last, i_clk, i_rst_n, o_valid && !o_last && i_ready, o_last)
    `PGR_ASSERT_NEXT(a_same_stamp, i_clk, i_rst_n, o_valid && !o_last && i_ready, $stable(o_stamp_ms))
    // an up result is always followed by its click or double click
    `PGR_ASSERT_NOW(a_up_not_last, i_clk, i_rst_n, o_valid && (o_kind == KIND_UP), !o_last)

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the pointer gesture recognizer: directed and random requests.
`timescale 1ns / 1ps

module testbench;
    import pgr_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          IDLE_SETTLE  = 8;
    localparam int          SINK_HOLD    = 200;
    localparam logic [2:0]  MODE_SPARE   = 3'd5;

    // one expected result, at the output widths
    typedef struct packed {
        t_kind       kind;
        logic [15:0] at_x;
        logic [15:0] at_y;
        logic [31:0] stamp;
        logic        last;
    } t_gesture_event;

    // gesture predictor plus queue of results it still owes
    class t_gesture_scoreboard;
        logic [15:0]        dc_window;
        logic [7:0]         slop;
        logic [7:0]         cancel;
        logic [15:0]        long_ms;
        bit                 held;
        bit                 fired;
        logic signed [15:0] press_x;
        logic signed [15:0] press_y;
        logic [31:0]        press_t;
        logic [31:0]        click_t;
        logic signed [15:0] click_x;
        logic signed [15:0] click_y;
        t_gesture_event     expected_events[$];
        int                 n_errors;

        function new();
            dc_window = RST_DC_WINDOW;
            slop      = RST_SLOP;
            cancel    = RST_CANCEL;
            long_ms   = RST_LONG;
            held      = 1'b0;
            fired     = 1'b0;
            press_x   = '0;
            press_y   = '0;
            press_t   = '0;
            click_t   = '0;
            click_x   = '0;
            click_y   = '0;
            n_errors  = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CFG_DC_WINDOW: dc_window = data;
                CFG_SLOP:      slop = data[7:0];
                CFG_CANCEL:    cancel = data[7:0];
                CFG_LONG:      long_ms = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function int unsigned axis_dist(logic signed [15:0] a, logic signed [15:0] b);
            int d;
            d = int'(a) - int'(b);
            return (d < 0) ? -d : d;
        endfunction

        function t_gesture_event make_event(t_kind k, logic [15:0] x, logic [15:0] y,
                                            logic [31:0] t);
            t_gesture_event ev;
            ev.kind  = k;
            ev.at_x  = x;
            ev.at_y  = y;
            ev.stamp = t;
            ev.last  = 1'b0;
            return ev;
        endfunction

        // accepted request: advance gesture state, queue the results it causes
        function void note_request(logic [2:0] mode, logic signed [15:0] x,
                                   logic signed [15:0] y, logic [31:0] t);
            t_gesture_event batch[$];
            t_gesture_event ev;
            logic [31:0]    since;
            if (mode == MODE_LPRESS) begin
                batch.push_back(make_event(KIND_DOWN, x, y, t));
                held    = 1'b1;
                press_x = x;
                press_y = y;
                press_t = t;
                fired   = 1'b0;
            end else if (mode == MODE_LRELEASE) begin
                if (fired) begin
                    // release after a long press is swallowed
                    held  = 1'b0;
                    fired = 1'b0;
                end else begin
                    batch.push_back(make_event(KIND_UP, x, y, t));
                    since = t - click_t;
                    if (since < {16'd0, dc_window} && axis_dist(x, click_x) < slop &&
                        axis_dist(y, click_y) < slop) begin
                        batch.push_back(make_event(KIND_DOUBLE, x, y, t));
                        click_t = '0;
                    end else begin
                        batch.push_back(make_event(KIND_CLICK, x, y, t));
                        click_t = t;
                        click_x = x;
                        click_y = y;
                    end
                    held = 1'b0;
                end
            end else if (mode == MODE_RPRESS) begin
                batch.push_back(make_event(KIND_RIGHT, x, y, t));
            end else if (mode == MODE_MOTION) begin
                batch.push_back(make_event(KIND_MOVE, x, y, t));
                if (held && (axis_dist(x, press_x) > cancel || axis_dist(y, press_y) > cancel))
                    held = 1'b0;
            end

            // hold check runs after every request
            since = t - press_t;
            if (held && !fired && since >= {16'd0, long_ms}) begin
                batch.push_back(make_event(KIND_RIGHT, press_x, press_y, t));
                fired = 1'b1;
                held  = 1'b0;
            end

            foreach (batch[i]) begin
                ev = batch[i];
                ev.last = (i == batch.size() - 1);
                expected_events.push_back(ev);
            end
        endfunction

        function void record_mismatch(string msg);
            n_errors++;
            if (n_errors <= 10)
                $display("%s", msg);
        endfunction

        // accepted result: compare with the oldest expectation
        function void check_result(logic [2:0] kind, logic [15:0] x, logic [15:0] y,
                                   logic [31:0] stamp, logic last);
            t_gesture_event want;
            if (expected_events.size() == 0) begin
                record_mismatch($sformatf(
                    "unexpected result: kind %0d x %h y %h stamp %h last %0d",
                    kind, x, y, stamp, last));
                return;
            end
            want = expected_events.pop_front();
            if (kind !== want.kind || x !== want.at_x || y !== want.at_y ||
                stamp !== want.stamp || last !== want.last)
                record_mismatch({
                    $sformatf("result mismatch: expected kind %0d x %h y %h stamp %h last %0d",
                              want.kind, want.at_x, want.at_y, want.stamp, want.last),
                    $sformatf(", got kind %0d x %h y %h stamp %h last %0d",
                              kind, x, y, stamp, last)});
        endfunction
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_cfg_we   = 1'b0;
    logic [1:0]         i_cfg_idx  = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_valid    = 1'b0;
    logic               o_ready;
    logic [2:0]         i_mode     = '0;
    logic signed [15:0] i_pos_x    = '0;
    logic signed [15:0] i_pos_y    = '0;
    logic [31:0]        i_time_ms  = '0;
    logic               o_valid;
    logic               i_ready    = 1'b0;
    logic [2:0]         o_kind;
    logic signed [15:0] o_at_x;
    logic signed [15:0] o_at_y;
    logic [31:0]        o_stamp_ms;
    logic               o_last;

    t_gesture_scoreboard scoreboard = new();
    logic [31:0]        cur_time      = '0;
    logic [15:0]        base_x        = '0;
    logic [15:0]        base_y        = '0;
    bit                 src_idle_en   = 1'b1;
    bit                 sink_idle_en  = 1'b1;
    bit                 sink_hold_req = 1'b0;
    int                 gestures_sent = 0;
    int                 cycle_count   = 0;

    pointer_gesture_recognizer_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_time_ms  (i_time_ms),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_at_x     (o_at_x),
        .o_at_y     (o_at_y),
        .o_stamp_ms (o_stamp_ms),
        .o_last     (o_last)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // drop valid and let the request side sit idle for a span set by n
    task automatic hold_off(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // offer one request and wait for it to be taken
    task automatic send_request(logic [2:0] mode, logic [15:0] x, logic [15:0] y,
                                logic [31:0] t);
        if (src_idle_en && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 8));
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_pos_x   <= x;
        i_pos_y   <= y;
        i_time_ms <= t;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        scoreboard.note_request(mode, x, y, t);
        if (mode <= MODE_TICK)
            gestures_sent++;
    endtask

    // wait until every owed result is out, then let silent requests finish
    task automatic drain_results();
        i_valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // write all four registers back to back; block must be idle
    task automatic configure(logic [15:0] dcw, logic [7:0] slp, logic [7:0] cnc,
                             logic [15:0] lng);
        logic [1:0]  idxs [4];
        logic [15:0] vals [4];
        idxs = '{CFG_DC_WINDOW, CFG_SLOP, CFG_CANCEL, CFG_LONG};
        vals = '{dcw, {8'($urandom), slp}, {8'($urandom), cnc}, lng};
        for (int r = 0; r < 4; r++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[r];
            i_cfg_data <= vals[r];
            @(posedge i_clk);
            scoreboard.set_register(idxs[r], vals[r]);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] jitter(logic [15:0] c, int r);
        return c + 16'($urandom_range(0, 2 * r)) - 16'(r);
    endfunction

    // time step: often short, often near a threshold, sometimes up to twice the hold time, now and then anything
    function automatic logic [31:0] pick_dt();
        int unsigned sel;
        int          span;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return $urandom_range(0, 30);
        if (sel < 60)
            span = int'(scoreboard.dc_window);
        else if (sel < 80)
            span = int'(scoreboard.long_ms);
        else if (sel < 97)
            return $urandom_range(0, 2 * int'(scoreboard.long_ms) + 2);
        else
            return $urandom;
        span = span + int'($urandom_range(0, 4)) - 2;
        return (span < 0) ? 0 : span;
    endfunction

    // one random gesture: press/hold/move/release, a right press, or noise
    task automatic run_gesture();
        int unsigned pick;
        int unsigned steps;
        logic [15:0] px;
        logic [15:0] py;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 4) begin
            base_x = 16'($urandom);
            base_y = 16'($urandom);
        end
        if (pick < 15) begin
            // any mode code, anywhere, at any time
            if ($urandom_range(0, 3) == 0)
                cur_time = $urandom;
            else
                cur_time += pick_dt();
            send_request(3'($urandom), 16'($urandom), 16'($urandom), cur_time);
        end else if (pick < 22) begin
            cur_time += pick_dt();
            send_request(MODE_RPRESS, jitter(base_x, 40), jitter(base_y, 40), cur_time);
        end else begin
            px = jitter(base_x, int'(scoreboard.slop) + 2);
            py = jitter(base_y, int'(scoreboard.slop) + 2);
            cur_time += pick_dt();
            send_request(MODE_LPRESS, px, py, cur_time);
            steps = $urandom_range(0, 3);
            for (int j = 0; j < steps; j++) begin
                cur_time += pick_dt();
                if ($urandom_range(0, 1) == 0)
                    send_request(MODE_TICK, 16'($urandom), 16'($urandom), cur_time);
                else
                    send_request(MODE_MOTION, jitter(px, int'(scoreboard.cancel) + 2),
                                 jitter(py, int'(scoreboard.cancel) + 2), cur_time);
            end
            cur_time += pick_dt();
            send_request(MODE_LRELEASE, jitter(base_x, int'(scoreboard.slop) + 2),
                         jitter(base_y, int'(scoreboard.slop) + 2), cur_time);
        end
    endtask

    // result side: check accepted results, drive ready with random stalls
    initial begin : result_sink
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                scoreboard.check_result(o_kind, o_at_x, o_at_y, o_stamp_ms, o_last);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                hold_left = SINK_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                i_ready <= 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(1, 8) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // request side
    initial begin : stimulus
        int          target;
        logic [15:0] dcw;
        logic [15:0] lng;
        logic [7:0]  slp;
        logic [7:0]  cnc;
        bit          pressure_done;
        bit          paused;
        pressure_done = 1'b0;
        paused        = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // release with nothing held near the origin: double click against reset state
        send_request(MODE_LRELEASE, 16'h0000, 16'h0000, 32'd100);
        // press at the coordinate extremes, small motion keeps the hold
        send_request(MODE_LPRESS, 16'h8000, 16'h7FFF, 32'd1000);
        send_request(MODE_MOTION, 16'h8003, 16'h7FF9, 32'd1100);
        // tick past the hold time fires a right click at the press point
        send_request(MODE_TICK, 16'h7FFF, 16'h8000, 32'd1800);
        // release after the long press is swallowed
        send_request(MODE_LRELEASE, 16'h0000, 16'h0000, 32'd1900);
        send_request(MODE_RPRESS, 16'h7FFF, 16'h8000, 32'd2000);
        // motion beyond the cancel distance, then a late tick does nothing
        send_request(MODE_LPRESS, 16'd100, 16'd100, 32'd3000);
        send_request(MODE_MOTION, 16'd111, 16'd100, 32'd3100);
        send_request(MODE_TICK, 16'h0000, 16'h0000, 32'd4000);
        send_request(MODE_LRELEASE, 16'd100, 16'd100, 32'd4100);
        // second click close by and in time
        send_request(MODE_LPRESS, 16'd101, 16'd101, 32'd4200);
        send_request(MODE_LRELEASE, 16'd104, 16'd96, 32'd4300);
        // spare mode codes
        for (int k = 0; k < 3; k++)
            send_request(MODE_SPARE + 3'(k), 16'hFFFF, 16'hFFFF, 32'd4400 + k);
        // hold across the time wrap
        send_request(MODE_LPRESS, 16'hFFFF, 16'h0001, 32'hFFFF_FF00);
        send_request(MODE_TICK, 16'h0000, 16'h0000, 32'h0000_0300);
        send_request(MODE_LRELEASE, 16'hFFFF, 16'h0001, 32'hFFFF_FFFF);
        // zero hold time: right click right behind the down
        drain_results();
        configure(RST_DC_WINDOW, RST_SLOP, RST_CANCEL, 16'd0);
        send_request(MODE_LPRESS, 16'd5, 16'hFFFB, 32'h0000_1000);
        send_request(MODE_LRELEASE, 16'd5, 16'hFFFB, 32'h0000_1010);
        cur_time = 32'h0000_2000;

        // random phases, each configured before it runs; phases 0, 3 and 7 share the reset values
        for (int phase = 0; phase < 8; phase++) begin
            drain_results();
            case (phase)
                1: begin
                    dcw = 16'd0; slp = 8'd0; cnc = 8'd0; lng = 16'd0;
                end
                2: begin
                    dcw = 16'hFFFF; slp = 8'hFF; cnc = 8'hFF; lng = 16'hFFFF;
                end
                5: begin
                    dcw = 16'd1; slp = 8'hFF; cnc = 8'd0; lng = 16'd1;
                end
                0, 3, 7: begin
                    dcw = RST_DC_WINDOW; slp = RST_SLOP; cnc = RST_CANCEL; lng = RST_LONG;
                end
                default: begin
                    dcw = 16'($urandom_range(0, 2000));
                    slp = 8'($urandom_range(0, 20));
                    cnc = 8'($urandom_range(0, 30));
                    lng = 16'($urandom_range(0, 3000));
                end
            endcase
            configure(dcw, slp, cnc, lng);
            // phase 4 runs without stalls, the closing phase too
            src_idle_en  = (phase != 4) && (phase != 7);
            sink_idle_en = (phase != 4) && (phase != 7);
            target = gestures_sent + 100;
            while (gestures_sent < target) begin
                run_gesture();
                if (phase == 3 && !pressure_done && gestures_sent + 70 >= target) begin
                    // result side holds off while requests keep coming
                    pressure_done = 1'b1;
                    src_idle_en   = 1'b0;
                    sink_hold_req = 1'b1;
                    for (int k = 0; k < 16; k++)
                        run_gesture();
                    src_idle_en = 1'b1;
                end
                if (phase == 5 && !paused && gestures_sent + 50 >= target) begin
                    // request side pauses until everything is out
                    paused = 1'b1;
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (IDLE_SETTLE) @(posedge i_clk);
        if (scoreboard.n_errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
